>>> design/assert_macros.svh
// Assertion macros used by the walker unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/fcw_pkg.sv
// Types and constants of the FAT12 cluster chain walker.
package fcw_pkg;
	localparam int TABLE_BYTES = 8192;
	localparam int TBL_AW = $clog2(TABLE_BYTES);

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_OPEN = 2'd1;
	localparam logic [1:0] MODE_ADV  = 2'd2;

	localparam logic [11:0] ENTRY_MASK = 12'hFFF;
	localparam logic [11:0] END_MARK   = 12'hFF8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPC        = 1'd1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [12:0] table_index;
		logic [7:0]  table_byte;
		logic        contiguous;
		logic [31:0] start_value;
	} fcw_in_t;

	typedef struct packed {
		logic        sector_valid;
		logic [31:0] sector_lba;
		logic        end_of_chain;
	} fcw_out_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] cluster;
		logic [7:0]  sector;
		logic [7:0]  spc;
	} fcw_lba_req_t;
endpackage

>>> design/fcw_lba.sv
// Two-stage sector address unit: base + (cluster - 2) * spc + sector.
module fcw_lba (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  fcw_pkg::fcw_lba_req_t op,
	output logic                 done,
	output logic [31:0]          lba
);
	logic        go_s1;
	logic [31:0] prod_s1;
	logic [31:0] base_s1;
	logic        done_s2;
	logic [31:0] lba_s2;
	logic [31:0] prod_full;

	// Only the low 32 bits of the product matter, since the address wraps.
	assign prod_full = (op.cluster - 32'd2) * {24'd0, op.spc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1   <= 1'b0;
			prod_s1 <= '0;
			base_s1 <= '0;
			done_s2 <= 1'b0;
			lba_s2  <= '0;
		end else begin
			go_s1   <= go;
			prod_s1 <= prod_full;
			base_s1 <= op.base + {24'd0, op.sector};
			done_s2 <= go_s1;
			lba_s2  <= base_s1 + prod_s1;
		end
	end

	assign done = done_s2;
	assign lba  = lba_s2;
endmodule

>>> design/fat12_cluster_chain_walker_unit.sv
// Top level of the FAT12 cluster chain walker: control, table memory and output register.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | fcw_in_t word: load, open or advance
//   rsp     | out | rsp_valid/rsp_ready  | fcw_out_t word: sector address, end flag
//   cfg     | in  | cfg_we               | cfg_index, cfg_wdata
//
// One word is in flight at a time. Load and contiguous open or advance go straight to emit;
// an open of a cluster and an advance inside a cluster pass through the two-stage address
// multiply, and an advance that follows the table first makes two reads of the single-ported
// table memory for the 12-bit entry. A stalled rsp holds the finished word in the output
// register; the block keeps one more result pending and takes no new word until it moves on.
// Reset clears walk state and registers, spc to 1; the table is undefined until loaded.
`include "assert_macros.svh"
module fat12_cluster_chain_walker_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  fcw_pkg::fcw_in_t                    req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output fcw_pkg::fcw_out_t                   rsp,
	input  logic                                cfg_we,
	input  logic [fcw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fcw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	typedef enum logic [3:0] {
		S_IDLE, S_IDX, S_RLO, S_RHI, S_CHECK, S_LBA, S_WAIT, S_EMIT
	} state_t;

	state_t state_q;
	logic [31:0] data_start_q;
	logic [7:0]  spc_q;
	logic [31:0] cluster_q;
	logic [7:0]  sector_q;
	logic        seq_q;
	logic        done_q;
	logic [fcw_pkg::TBL_AW-1:0] idx_q;
	logic        oor_q;
	logic [7:0]  lo_q;
	fcw_pkg::fcw_out_t res_q;
	fcw_pkg::fcw_out_t rsp_q;
	logic        rsp_valid_q;

	logic [7:0]  tbl_mem [fcw_pkg::TABLE_BYTES];
	logic [7:0]  rd_data_q;
	logic        mem_we;
	logic [fcw_pkg::TBL_AW-1:0] mem_addr;

	logic [7:0]  nsec;
	logic [33:0] idx_full;
	logic [32:0] idx_byte;
	logic [15:0] entry_word;
	logic [31:0] next_cluster;
	logic        accept;
	logic        emit;
	logic        lba_go;
	logic        lba_done;
	logic [31:0] lba_val;
	fcw_pkg::fcw_lba_req_t lba_op;

	assign accept     = req_valid && req_ready;
	assign req_ready  = (state_q == S_IDLE);
	assign emit       = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);
	assign nsec       = sector_q + 8'd1;
	assign idx_full   = {2'b00, cluster_q} + {1'b0, cluster_q, 1'b0};
	assign idx_byte   = idx_full[33:1];
	assign entry_word = {rd_data_q, lo_q};
	// Even clusters keep the low 12 bits, odd clusters the upper 12.
	assign next_cluster = cluster_q[0] ? {20'd0, entry_word[15:4]}
		: {20'd0, entry_word[11:0] & fcw_pkg::ENTRY_MASK};

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				mem_addr = req.table_index[fcw_pkg::TBL_AW-1:0];
				mem_we   = accept && (req.mode == fcw_pkg::MODE_LOAD)
					&& (32'(req.table_index) < fcw_pkg::TABLE_BYTES);
			end
			S_RLO: mem_addr = idx_q + fcw_pkg::TBL_AW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_addr] <= req.table_byte;
		end
		rd_data_q <= tbl_mem[mem_addr];
	end

	assign lba_go = (state_q == S_LBA);
	assign lba_op = '{base: data_start_q, cluster: cluster_q, sector: sector_q, spc: spc_q};

	fcw_lba u_lba (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (lba_go),
		.op     (lba_op),
		.done   (lba_done),
		.lba    (lba_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			data_start_q <= '0;
			spc_q        <= 8'd1;
			cluster_q    <= '0;
			sector_q     <= '0;
			seq_q        <= 1'b0;
			done_q       <= 1'b0;
			idx_q        <= '0;
			oor_q        <= 1'b0;
			lo_q         <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fcw_pkg::CFG_DATA_START: data_start_q <= cfg_wdata;
					fcw_pkg::CFG_SPC:        spc_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (emit) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.mode == fcw_pkg::MODE_OPEN) begin
							seq_q     <= req.contiguous;
							cluster_q <= req.start_value;
							sector_q  <= '0;
							done_q    <= 1'b0;
							if (req.contiguous) begin
								res_q <= '{sector_valid: 1'b1, sector_lba: req.start_value,
									end_of_chain: 1'b0};
								state_q <= S_EMIT;
							end else begin
								state_q <= S_LBA;
							end
						end else if (req.mode == fcw_pkg::MODE_ADV && !done_q) begin
							if (seq_q) begin
								cluster_q <= cluster_q + 32'd1;
								res_q <= '{sector_valid: 1'b1, sector_lba: cluster_q + 32'd1,
									end_of_chain: 1'b0};
								state_q <= S_EMIT;
							end else if (nsec >= spc_q) begin
								sector_q <= '0;
								idx_q    <= idx_byte[fcw_pkg::TBL_AW-1:0];
								oor_q    <= (idx_byte >= 33'(fcw_pkg::TABLE_BYTES - 1));
								state_q  <= S_IDX;
							end else begin
								sector_q <= nsec;
								state_q  <= S_CHECK;
							end
						end else begin
							res_q   <= '{sector_valid: 1'b0, sector_lba: '0,
								end_of_chain: done_q};
							state_q <= S_EMIT;
						end
					end
				end
				S_IDX: begin
					// An entry that runs past the table reads as all ones.
					if (oor_q) begin
						cluster_q <= {20'd0, fcw_pkg::ENTRY_MASK};
						state_q   <= S_CHECK;
					end else begin
						state_q <= S_RLO;
					end
				end
				S_RLO: begin
					lo_q    <= rd_data_q;
					state_q <= S_RHI;
				end
				S_RHI: begin
					cluster_q <= next_cluster;
					state_q   <= S_CHECK;
				end
				S_CHECK: begin
					if (cluster_q >= 32'(fcw_pkg::END_MARK)) begin
						done_q  <= 1'b1;
						res_q   <= '{sector_valid: 1'b0, sector_lba: '0, end_of_chain: 1'b1};
						state_q <= S_EMIT;
					end else begin
						state_q <= S_LBA;
					end
				end
				S_LBA: state_q <= S_WAIT;
				S_WAIT: begin
					if (lba_done) begin
						res_q   <= '{sector_valid: 1'b1, sector_lba: lba_val, end_of_chain: 1'b0};
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_IMPLIES(a_valid_not_end, clk, arst_n, rsp_valid && rsp.sector_valid, !rsp.end_of_chain)
	`ASSERT_IMPLIES(a_idle_lba_zero, clk, arst_n, rsp_valid && !rsp.sector_valid, rsp.sector_lba == 32'd0)
	`ASSERT_IMPLIES(a_lba_in_wait, clk, arst_n, lba_done, state_q == S_WAIT)
	`ASSERT_IMPLIES(a_read_in_range, clk, arst_n, state_q == S_RLO, !oor_q && !mem_we)
endmodule

>>> bench/fat12_walk_checker.sv
// Response checker for the FAT12 cluster chain walker: predicts each sector word and compares it.
module fat12_walk_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_ready,
	input  fcw_pkg::fcw_in_t                   req,
	input  logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  fcw_pkg::fcw_out_t                  rsp,
	input  logic                               cfg_we,
	input  logic [fcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output int                                 fail_count,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import fcw_pkg::*;

	logic [7:0]  fat_bytes [TABLE_BYTES];
	logic [31:0] cur_cluster;
	logic [7:0]  cur_sector;
	logic        seq_walk;
	logic        walk_ended;
	logic [31:0] data_base;
	logic [7:0]  spc;
	fcw_out_t    sector_words [$];
	int          n_fail;

	function automatic logic [31:0] next_cluster(input logic [31:0] c);
		logic [63:0] pos;
		logic [63:0] pos_hi;
		logic [15:0] pair;
		pos = ({32'd0, c} * 64'd3) / 64'd2;
		pos_hi = pos + 64'd1;
		// An entry that would straddle the end of the table reads as end of chain.
		if (pos_hi >= TABLE_BYTES)
			return {20'd0, ENTRY_MASK};
		pair = {fat_bytes[pos_hi[TBL_AW-1:0]], fat_bytes[pos[TBL_AW-1:0]]};
		return c[0] ? {20'd0, pair[15:4]} : {20'd0, pair[11:0] & ENTRY_MASK};
	endfunction

	function automatic logic [31:0] cluster_sector();
		return data_base + (cur_cluster - 32'd2) * {24'd0, spc} + {24'd0, cur_sector};
	endfunction

	function automatic fcw_out_t walk_step(input fcw_in_t w);
		fcw_out_t r;
		r = '0;
		case (w.mode)
		MODE_LOAD: fat_bytes[w.table_index] = w.table_byte;
		MODE_OPEN: begin
			seq_walk = w.contiguous;
			cur_cluster = w.start_value;
			cur_sector = '0;
			walk_ended = 1'b0;
			r.sector_valid = 1'b1;
			r.sector_lba = w.contiguous ? cur_cluster : cluster_sector();
		end
		MODE_ADV: if (!walk_ended) begin
			if (seq_walk) begin
				cur_cluster = cur_cluster + 32'd1;
				r.sector_valid = 1'b1;
				r.sector_lba = cur_cluster;
			end else begin
				cur_sector = cur_sector + 8'd1;
				if (cur_sector >= spc) begin
					cur_sector = '0;
					cur_cluster = next_cluster(cur_cluster);
				end
				if (cur_cluster >= {20'd0, END_MARK}) begin
					walk_ended = 1'b1;
				end else begin
					r.sector_valid = 1'b1;
					r.sector_lba = cluster_sector();
				end
			end
		end
		default: ;
		endcase
		r.end_of_chain = walk_ended;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		n_fail++;
		$display("%0t walker mismatch: %s got %0h expected %0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		fcw_out_t want;
		if (!arst_n) begin
			cur_cluster = '0;
			cur_sector = '0;
			seq_walk = 1'b0;
			walk_ended = 1'b0;
			data_base = '0;
			spc = 8'd1;
			sector_words.delete();
			n_fail = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_DATA_START: data_base = cfg_wdata;
				CFG_SPC: spc = cfg_wdata[7:0];
				default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (sector_words.size() == 0) begin
					report_mismatch("word with none outstanding", rsp.sector_lba, '0);
				end else begin
					want = sector_words.pop_front();
					if (rsp.sector_valid !== want.sector_valid)
						report_mismatch("sector_valid", {31'd0, rsp.sector_valid},
							{31'd0, want.sector_valid});
					if (rsp.sector_lba !== want.sector_lba)
						report_mismatch("sector_lba", rsp.sector_lba, want.sector_lba);
					if (rsp.end_of_chain !== want.end_of_chain)
						report_mismatch("end_of_chain", {31'd0, rsp.end_of_chain},
							{31'd0, want.end_of_chain});
				end
			end
			if (req_valid && req_ready)
				sector_words.push_back(walk_step(req));
			fail_count <= n_fail;
			pending <= sector_words.size();
		end
	end
endmodule

>>> bench/fat12_cluster_chain_walker_unit_test.sv
// Testbench top of the FAT12 cluster chain walker: reset, stimulus, back-pressure and verdict.
module fat12_cluster_chain_walker_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fcw_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_WORDS  = 220;
	localparam int RANDOM_WORDS = 1550;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	fcw_in_t               req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	fcw_out_t              rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending;
	int                    hold_asks;
	int                    words_sent;

	// Walk state as the stimulus sees it, so that no table read lands on an unwritten byte.
	logic [7:0]  fat_copy [TABLE_BYTES];
	bit          fat_known [TABLE_BYTES];
	logic [31:0] at_cluster;
	logic [7:0]  at_sector;
	logic        at_seq;
	logic        at_end;
	logic [7:0]  at_spc;

	fat12_cluster_chain_walker_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	fat12_walk_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Mostly short gaps, a few long ones, and every fourth stretch of 64 with none at all.
	function automatic int gap_len(input int n);
		int r;
		if ((n / 64) % 4 == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] fat_pos(input logic [31:0] c);
		return ({32'd0, c} * 64'd3) / 64'd2;
	endfunction

	function automatic fcw_in_t random_fields(input logic [1:0] mode);
		fcw_in_t w;
		w.mode = mode;
		w.table_index = 13'($urandom);
		w.table_byte = 8'($urandom);
		w.contiguous = 1'($urandom);
		w.start_value = $urandom;
		return w;
	endfunction

	// True when the next advance would fetch a table entry whose bytes were never loaded.
	function automatic bit needs_entry();
		logic [63:0] pos;
		logic [63:0] pos_hi;
		logic [7:0]  nxt;
		nxt = at_sector + 8'd1;
		pos = fat_pos(at_cluster);
		pos_hi = pos + 64'd1;
		if (at_end || at_seq || nxt < at_spc || pos_hi >= TABLE_BYTES)
			return 1'b0;
		return !(fat_known[pos[TBL_AW-1:0]] && fat_known[pos_hi[TBL_AW-1:0]]);
	endfunction

	function automatic logic [11:0] pick_link();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 12'($urandom_range(2, 400));
		if (r < 82)
			return 12'($urandom_range(32'hFF8, 32'hFFF));
		if (r < 87)
			return 12'($urandom_range(0, 1));
		return 12'($urandom);
	endfunction

	task automatic follow_word(input fcw_in_t w);
		logic [63:0] pos;
		logic [63:0] pos_hi;
		logic [15:0] pair;
		case (w.mode)
		MODE_LOAD: begin
			fat_copy[w.table_index] = w.table_byte;
			fat_known[w.table_index] = 1'b1;
		end
		MODE_OPEN: begin
			at_seq = w.contiguous;
			at_cluster = w.start_value;
			at_sector = '0;
			at_end = 1'b0;
		end
		MODE_ADV: if (!at_end) begin
			if (at_seq) begin
				at_cluster = at_cluster + 32'd1;
			end else begin
				at_sector = at_sector + 8'd1;
				if (at_sector >= at_spc) begin
					at_sector = '0;
					pos = fat_pos(at_cluster);
					pos_hi = pos + 64'd1;
					if (pos_hi >= TABLE_BYTES) begin
						at_cluster = {20'd0, ENTRY_MASK};
					end else begin
						pair = {fat_copy[pos_hi[TBL_AW-1:0]], fat_copy[pos[TBL_AW-1:0]]};
						at_cluster = at_cluster[0] ? {20'd0, pair[15:4]} : {20'd0, pair[11:0]};
					end
				end
				at_end = (at_cluster >= {20'd0, END_MARK});
			end
		end
		default: ;
		endcase
	endtask

	// Offers one word and returns at the edge where it was taken.
	task automatic send_word(input fcw_in_t w);
		int gap;
		gap = gap_len(words_sent);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		words_sent++;
		follow_word(w);
	endtask

	task automatic load_byte(input logic [TBL_AW-1:0] idx, input logic [7:0] b);
		fcw_in_t w;
		w = random_fields(MODE_LOAD);
		w.table_index = idx;
		w.table_byte = b;
		send_word(w);
	endtask

	task automatic open_chain(input logic contig, input logic [31:0] start);
		fcw_in_t w;
		w = random_fields(MODE_OPEN);
		w.contiguous = contig;
		w.start_value = start;
		send_word(w);
	endtask

	// Writes the 12-bit link of cluster c, keeping the nibble that belongs to its neighbor.
	task automatic set_entry(input logic [31:0] c, input logic [11:0] v);
		logic [63:0] pos;
		logic [7:0]  lo;
		logic [7:0]  hi;
		pos = fat_pos(c);
		lo = fat_known[pos[TBL_AW-1:0]] ? fat_copy[pos[TBL_AW-1:0]] : 8'($urandom);
		load_byte(pos[TBL_AW-1:0], 8'd0 | lo);
		pos = pos + 64'd1;
		hi = fat_known[pos[TBL_AW-1:0]] ? fat_copy[pos[TBL_AW-1:0]] : 8'($urandom);
		if (c[0]) begin
			hi = v[11:4];
			lo[7:4] = v[3:0];
		end else begin
			lo = v[7:0];
			hi[3:0] = v[11:8];
		end
		pos = pos - 64'd1;
		fat_copy[pos[TBL_AW-1:0]] = lo;
		load_byte(pos[TBL_AW-1:0], lo);
		pos = pos + 64'd1;
		load_byte(pos[TBL_AW-1:0], hi);
	endtask

	task automatic step_sector();
		if (needs_entry())
			set_entry(at_cluster, pick_link());
		send_word(random_fields(MODE_ADV));
	endtask

	task automatic open_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			open_chain(1'b1, $urandom);
		else if (r < 25)
			open_chain(1'b1, 32'hFFFF_FFFF - $urandom_range(0, 3));
		else if (r < 80)
			open_chain(1'b0, $urandom_range(2, 400));
		else if (r < 85)
			open_chain(1'b0, $urandom_range(0, 1));
		else if (r < 90)
			open_chain(1'b0, $urandom_range(32'hFF8, 32'hFFF));
		else if (r < 95)
			open_chain(1'b0, $urandom_range(5461, 65535));
		else
			open_chain(1'b0, $urandom);
	endtask

	// Stops offering words and waits until every expected word has come back.
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [31:0] base, input logic [7:0] spc);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DATA_START;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= CFG_SPC;
		cfg_wdata <= {24'd0, spc};
		@(posedge clk);
		cfg_we <= 1'b0;
		at_spc = spc;
	endtask

	// Receiver side: random stalls, plus a long hold-off whenever the sender asks for one.
	initial begin
		int gap;
		int served;
		int beats;
		served = 0;
		beats = 0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			beats++;
			if (hold_asks > served) begin
				served++;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = gap_len(beats);
				if (gap > 0) begin
					rsp_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		int r;
		int stop_at;
		int next_cfg;
		int hold_at;
		int phase;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		hold_asks = 0;
		words_sent = 0;
		at_cluster = '0;
		at_sector = '0;
		at_seq = 1'b0;
		at_end = 1'b0;
		at_spc = 8'd1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cfg(32'h0000_1000, 8'd2);
		send_word(random_fields(MODE_SPARE));
		step_sector();
		set_entry(32'd2, 12'h003);
		set_entry(32'd3, END_MARK);
		load_byte(13'h1FFF, 8'hFF);
		load_byte(13'h0000, 8'h00);
		// Two clusters of two sectors, the end, then one advance past the end.
		open_chain(1'b0, 32'd2);
		repeat (5) step_sector();
		send_word(random_fields(MODE_SPARE));
		open_chain(1'b1, 32'hFFFF_FFFF);
		step_sector();
		step_sector();
		open_chain(1'b0, 32'd0);
		open_chain(1'b0, 32'hFFFF_FFFF);
		step_sector();
		// First cluster whose entry would run past the end of the table.
		open_chain(1'b0, 32'd5461);
		step_sector();
		step_sector();
		settle();
		write_cfg(32'hFFFF_FFFF, 8'd0);
		open_chain(1'b0, 32'd2);
		repeat (3) step_sector();
		settle();

		stop_at = words_sent + RANDOM_WORDS;
		next_cfg = words_sent + PHASE_WORDS;
		hold_at = words_sent + 330;
		phase = 0;
		while (words_sent < stop_at) begin
			if (words_sent >= next_cfg) begin
				settle();
				case (phase % 6)
				0: write_cfg(32'd0, 8'd1);
				1: write_cfg(32'hFFFF_FFFF, 8'd128);
				2: write_cfg($urandom, 8'd0);
				3: write_cfg($urandom, 8'd255);
				4: write_cfg($urandom, 8'($urandom_range(2, 8)));
				default: write_cfg($urandom, 8'($urandom_range(1, 128)));
				endcase
				phase++;
				next_cfg = words_sent + PHASE_WORDS;
			end
			if (words_sent >= hold_at) begin
				hold_asks <= hold_asks + 1;
				hold_at = hold_at + 600;
			end
			r = $urandom_range(0, 99);
			if ((at_end && r < 50) || r < 7)
				open_random();
			else if (r < 78)
				step_sector();
			else if (r < 85)
				load_byte(13'($urandom), 8'($urandom));
			else if (r < 93)
				set_entry($urandom_range(2, 400), pick_link());
			else
				send_word(random_fields(MODE_SPARE));
		end
		settle();

		if (fail_count == 0)
			$display("fat12_cluster_chain_walker_unit verification clean");
		else
			$display("fat12_cluster_chain_walker_unit verification failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("fat12_cluster_chain_walker_unit verification failed");
		$finish;
	end
endmodule
